>>> rtl/core/jsu_pkg.sv
// Shared types, codes and helpers for the JSON string unescape core.
package jsu_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned CodeW = 16;
  localparam int unsigned MaxOut = 3;

  localparam logic [KindW-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KindW-1:0] KIND_CLOSE = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR = 2'd2;

  localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [ByteW-1:0] CH_SLASH = 8'h2F;
  localparam logic [ByteW-1:0] CH_B = 8'h62;
  localparam logic [ByteW-1:0] CH_F = 8'h66;
  localparam logic [ByteW-1:0] CH_N = 8'h6E;
  localparam logic [ByteW-1:0] CH_R = 8'h72;
  localparam logic [ByteW-1:0] CH_T = 8'h74;
  localparam logic [ByteW-1:0] CH_U = 8'h75;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_STR  = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [ByteW-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      h.val = c[3:0];
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_space(input logic [ByteW-1:0] c);
    return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
  endfunction

endpackage

>>> rtl/core/json_string_unescape_core.sv
// Top level of the JSON string unescape core: byte decoder and result queue.
//
//  channel | dir | tdata             | tuser            | tlast
//  in_     | in  | char_byte[7:0]    | end_of_text      | -
//  out_    | out | out_byte[7:0]     | kind[1:0]        | last_of_run
//
// One input byte per cycle absent stalls: it is registered, decoded against the
// parse state, and its results land in a three-slot result register once it is
// free. Most bytes give zero or one result and flow at one per cycle unless the
// output stalls; the fourth hex digit of a \u escape gives up to three, drained
// one per cycle while out_tready is high, holding off input. Reset (rst_n low,
// synchronous) returns to idle; a stall on out_tready backs up into in_tready.
module json_string_unescape_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic       in_tuser,   // [0] end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] kind
  output logic       out_tlast
);

  // input register
  logic                      st_valid_r;
  logic [jsu_pkg::ByteW-1:0] st_byte_r;
  logic                      st_eot_r;

  // parse state
  jsu_pkg::phase_t           phase_r, phase_nxt;
  logic [1:0]                hex_cnt_r, hex_cnt_nxt;
  logic [jsu_pkg::CodeW-1:0] acc_r, acc_nxt;

  // result register
  logic                      rq_valid_r;
  logic [1:0]                rq_last_r;
  logic [1:0]                rq_idx_r;
  logic [jsu_pkg::KindW-1:0] rq_kind_r;
  logic [jsu_pkg::ByteW-1:0] rq_byte_r [jsu_pkg::MaxOut];

  // decode results
  logic [1:0]                dec_n;
  logic [jsu_pkg::KindW-1:0] dec_kind;
  logic [jsu_pkg::ByteW-1:0] dec_byte [jsu_pkg::MaxOut];
  jsu_pkg::hex_t             hx;
  logic [jsu_pkg::CodeW-1:0] cp;

  logic rq_done, rq_free, advance, in_xfer;

  assign rq_done = rq_valid_r && out_tready && (rq_idx_r == rq_last_r);
  assign rq_free = !rq_valid_r || rq_done;
  assign advance = st_valid_r && ((dec_n == 2'd0) || rq_free);
  assign in_tready = !st_valid_r || advance;
  assign in_xfer = in_tvalid && in_tready;

  assign hx = jsu_pkg::hex_decode(st_byte_r);
  assign cp = {acc_r[jsu_pkg::CodeW-5:0], hx.val};

  always_comb begin
    dec_n       = 2'd0;
    dec_kind    = jsu_pkg::KIND_BYTE;
    dec_byte[0] = '0;
    dec_byte[1] = '0;
    dec_byte[2] = '0;
    phase_nxt   = phase_r;
    hex_cnt_nxt = hex_cnt_r;
    acc_nxt     = acc_r;
    if (st_eot_r) begin
      dec_n    = 2'd1;
      dec_kind = jsu_pkg::KIND_ERROR;
      phase_nxt = jsu_pkg::PH_IDLE;
      hex_cnt_nxt = '0;
      acc_nxt  = '0;
    end else begin
      case (phase_r)
        jsu_pkg::PH_IDLE: begin
          if (st_byte_r == jsu_pkg::CH_QUOTE) begin
            phase_nxt = jsu_pkg::PH_STR;
          end else if (!jsu_pkg::is_space(st_byte_r)) begin
            dec_n    = 2'd1;
            dec_kind = jsu_pkg::KIND_ERROR;
          end
        end
        jsu_pkg::PH_STR: begin
          if (st_byte_r == jsu_pkg::CH_QUOTE) begin
            dec_n     = 2'd1;
            dec_kind  = jsu_pkg::KIND_CLOSE;
            phase_nxt = jsu_pkg::PH_IDLE;
          end else if (st_byte_r == jsu_pkg::CH_BSLASH) begin
            phase_nxt = jsu_pkg::PH_ESC;
          end else begin
            dec_n       = 2'd1;
            dec_byte[0] = st_byte_r;
          end
        end
        jsu_pkg::PH_ESC: begin
          dec_n     = 2'd1;
          phase_nxt = jsu_pkg::PH_STR;
          case (st_byte_r)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: begin
              dec_byte[0] = st_byte_r;
            end
            jsu_pkg::CH_B: dec_byte[0] = 8'h08;
            jsu_pkg::CH_F: dec_byte[0] = 8'h0C;
            jsu_pkg::CH_N: dec_byte[0] = 8'h0A;
            jsu_pkg::CH_R: dec_byte[0] = 8'h0D;
            jsu_pkg::CH_T: dec_byte[0] = 8'h09;
            jsu_pkg::CH_U: begin
              dec_n       = 2'd0;
              phase_nxt   = jsu_pkg::PH_HEX;
              hex_cnt_nxt = '0;
              acc_nxt     = '0;
            end
            default: begin
              dec_kind  = jsu_pkg::KIND_ERROR;
              phase_nxt = jsu_pkg::PH_IDLE;
              hex_cnt_nxt = '0;
              acc_nxt   = '0;
            end
          endcase
        end
        jsu_pkg::PH_HEX: begin
          if (!hx.ok) begin
            dec_n       = 2'd1;
            dec_kind    = jsu_pkg::KIND_ERROR;
            phase_nxt   = jsu_pkg::PH_IDLE;
            hex_cnt_nxt = '0;
            acc_nxt     = '0;
          end else if (hex_cnt_r == 2'd3) begin
            // code point complete: UTF-8 encode, 1 to 3 bytes
            if (cp[15:7] == '0) begin
              dec_n       = 2'd1;
              dec_byte[0] = cp[7:0];
            end else if (cp[15:11] == '0) begin
              dec_n       = 2'd2;
              dec_byte[0] = {3'b110, cp[10:6]};
              dec_byte[1] = {2'b10, cp[5:0]};
            end else begin
              dec_n       = 2'd3;
              dec_byte[0] = {4'b1110, cp[15:12]};
              dec_byte[1] = {2'b10, cp[11:6]};
              dec_byte[2] = {2'b10, cp[5:0]};
            end
            phase_nxt   = jsu_pkg::PH_STR;
            hex_cnt_nxt = '0;
            acc_nxt     = '0;
          end else begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
            acc_nxt     = cp;
          end
        end
        default: begin
          phase_nxt   = jsu_pkg::PH_IDLE;
          hex_cnt_nxt = '0;
          acc_nxt     = '0;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else if (in_tready) begin
      st_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      st_byte_r <= in_tdata;
      st_eot_r  <= in_tuser;
    end
  end

  // parse state moves when the registered byte is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= jsu_pkg::PH_IDLE;
      hex_cnt_r <= '0;
      acc_r     <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      acc_r     <= acc_nxt;
    end
  end

  // result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_valid_r <= 1'b0;
      rq_idx_r   <= '0;
    end else if (advance && (dec_n != 2'd0)) begin
      rq_valid_r <= 1'b1;
      rq_idx_r   <= '0;
    end else if (rq_done) begin
      rq_valid_r <= 1'b0;
      rq_idx_r   <= '0;
    end else if (rq_valid_r && out_tready) begin
      rq_idx_r <= rq_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (dec_n != 2'd0)) begin
      rq_last_r    <= dec_n - 2'd1;
      rq_kind_r    <= dec_kind;
      rq_byte_r[0] <= dec_byte[0];
      rq_byte_r[1] <= dec_byte[1];
      rq_byte_r[2] <= dec_byte[2];
    end
  end

  assign out_tvalid = rq_valid_r;
  assign out_tdata  = rq_byte_r[rq_idx_r];
  assign out_tuser  = rq_kind_r;
  assign out_tlast  = (rq_idx_r == rq_last_r);

endmodule

>>> rtl/core/jsu_checker.sv
// Port-level checks for the JSON string unescape core, bound to the top level.
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);

  // nothing comes out in the cycle after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // close and error transfers carry a zero byte and end their run
  a_ctrl_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != jsu_pkg::KIND_BYTE) |-> (out_tdata == '0) && out_tlast)
    else $error("close/error result malformed");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == jsu_pkg::KIND_BYTE) || (out_tuser == jsu_pkg::KIND_CLOSE) ||
                   (out_tuser == jsu_pkg::KIND_ERROR))
    else $error("illegal result kind");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) &&
                                  $stable(out_tlast))
    else $error("stalled result changed");

  // input is only held off while a result is waiting
  a_in_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

endmodule

bind json_string_unescape_core jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
